[design/sccp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sccp_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int UC_W    = 2;
    localparam int SEC_W   = 32;
    localparam int TYPE_W  = 3;
    localparam int CNT_W   = 32;

    localparam logic [UC_W-1:0]   MAX_USE      = UC_W'(3);
    localparam logic [TYPE_W-1:0] TYPE_FOREIGN = TYPE_W'(5);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [UC_W-1:0]  t_use;

    typedef enum logic [1:0] {
        ACT_READ      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_FLUSH     = 2'd2,
        ACT_FLUSH_CLR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FOREIGN = 2'd2
    } t_status;

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [TYPE_W-1:0] dtype;
    } t_tag;

    // use count store control: one read, one write, clear-all
    typedef struct packed {
        t_idx rd_addr;
        logic we;
        t_idx wr_addr;
        t_use wr_data;
        logic clr_all;
    } t_use_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        t_idx              slot;
        logic              fetch;
        logic              wb;
        logic [SEC_W-1:0]  wb_sector;
        logic [TYPE_W-1:0] wb_type;
        logic              direct;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

[design/sccp_tag_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sccp_tag_ram (
    input  wire                 i_clk,
    input  wire sccp_pkg::t_idx i_rd_addr,
    output sccp_pkg::t_tag      o_rd_data,
    input  wire                 i_we,
    input  wire sccp_pkg::t_idx i_wr_addr,
    input  wire sccp_pkg::t_tag i_wr_data
);
    import sccp_pkg::*;

    t_tag r_mem [ENTRIES];
    t_tag r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/sccp_use_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sccp_use_ram (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire sccp_pkg::t_use_cmd i_cmd,
    output sccp_pkg::t_use          o_rd_data
);
    import sccp_pkg::*;

    t_use               r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_ok;
    t_use               r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        // entries never written since the last clear read as zero
        r_rd_data <= r_ok[i_cmd.rd_addr] ? r_mem[i_cmd.rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_cmd.clr_all) begin
            r_ok <= '0;
        end else if (i_cmd.we) begin
            r_ok[i_cmd.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/sector_cache_clock_policy_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tag and clock-replacement controller for a 64-entry fully associative sector
// cache. A request is taken when i_start is high and o_busy is low; every
// result appears for exactly one cycle with o_result_valid and cannot be held
// off, so the receiver must take it on that cycle. Lookup scans the tag RAM
// one entry per cycle through its single read port. A range error, foreign
// write or disabled-cache access answers in the cycle after accept without a
// scan; a hit answers once the scan reaches its entry, and a miss scans every
// entry and then moves the clock hand, aging each entry it passes (up to 192),
// to a victim whose use count is zero. Flush streams one word per entry on
// consecutive cycles, the last one flagged by o_last. A flush while the
// cache is disabled gives no word. o_hit_count and o_miss_count track the
// counters and are valid with each word. The enable register is written on
// i_cfg_valid (always ready) and should only change while the block is idle.
module sector_cache_clock_policy_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    output logic                        o_busy,
    input  wire  [1:0]                  i_action,
    input  wire  [sccp_pkg::SEC_W-1:0]  i_sector,
    input  wire  [sccp_pkg::TYPE_W-1:0] i_device_type,
    input  wire  [sccp_pkg::SEC_W-1:0]  i_device_sectors,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic                        o_hit,
    output logic [sccp_pkg::IDX_W-1:0]  o_slot,
    output logic                        o_fetch_needed,
    output logic                        o_writeback_needed,
    output logic [sccp_pkg::SEC_W-1:0]  o_writeback_sector,
    output logic [sccp_pkg::TYPE_W-1:0] o_writeback_type,
    output logic                        o_direct_access,
    output logic                        o_last,
    output logic [sccp_pkg::CNT_W-1:0]  o_hit_count,
    output logic [sccp_pkg::CNT_W-1:0]  o_miss_count,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire                         i_cfg_data
);
    import sccp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CLOCK_RD,
        S_CLOCK,
        S_FLUSH
    } t_state;

    t_state             r_state;
    logic               r_enable;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_dirty;
    t_idx               r_hand;
    t_idx               r_idx;
    t_idx               r_prev;
    logic               r_q_ok;
    logic               r_write;
    logic [SEC_W-1:0]   r_sector;
    logic [TYPE_W-1:0]  r_type;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_misses;
    logic               r_out_valid;
    t_result            r_res;

    t_idx     tag_rd_addr;
    t_tag     tag_q;
    logic     tag_we;
    t_tag     tag_wr_data;
    t_use_cmd use_cmd;
    t_use     use_q;

    logic     accept;
    logic     hit_now;
    logic     victim_now;
    logic     prev_last;
    t_action  act;

    assign act       = t_action'(i_action);
    assign accept    = i_start && (r_state == S_IDLE);
    assign prev_last = &r_prev;
    assign hit_now   = (r_state == S_SEARCH) && r_q_ok && r_valid[r_prev] &&
                       (tag_q.sector == r_sector) && (tag_q.dtype == r_type);
    assign victim_now = (r_state == S_CLOCK) && (use_q == '0);

    always_comb begin
        use_cmd     = '0;
        tag_we      = 1'b0;
        tag_wr_data = '{sector: r_sector, dtype: r_type};
        case (r_state)
            S_SEARCH, S_FLUSH: begin
                tag_rd_addr = r_idx;
            end
            S_CLOCK_RD: begin
                tag_rd_addr = r_hand;
            end
            S_CLOCK: begin
                // prefetch the next hand position while deciding this one
                tag_rd_addr = IDX_W'(r_hand + 1'b1);
            end
            default: begin
                tag_rd_addr = r_idx;
            end
        endcase
        use_cmd.rd_addr = tag_rd_addr;

        if (hit_now) begin
            use_cmd.we      = 1'b1;
            use_cmd.wr_addr = r_prev;
            use_cmd.wr_data = (use_q < MAX_USE) ? UC_W'(use_q + 1'b1) : use_q;
        end else if (r_state == S_CLOCK) begin
            use_cmd.we      = 1'b1;
            use_cmd.wr_addr = r_hand;
            use_cmd.wr_data = victim_now ? MAX_USE : UC_W'(use_q - 1'b1);
        end
        tag_we = victim_now;

        use_cmd.clr_all = accept && r_enable && (act == ACT_FLUSH_CLR);
    end

    sccp_tag_ram u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_addr (tag_rd_addr),
        .o_rd_data (tag_q),
        .i_we      (tag_we),
        .i_wr_addr (r_hand),
        .i_wr_data (tag_wr_data)
    );

    sccp_use_ram u_use_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (use_cmd),
        .o_rd_data (use_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_hand      <= '0;
            r_idx       <= '0;
            r_prev      <= '0;
            r_q_ok      <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_write  <= (act == ACT_WRITE);
                        r_sector <= i_sector;
                        r_type   <= i_device_type;
                        r_idx    <= '0;
                        r_q_ok   <= 1'b0;
                        r_res    <= '0;
                        if (act == ACT_READ || act == ACT_WRITE) begin
                            if (i_sector >= i_device_sectors) begin
                                r_res.status <= ST_RANGE;
                                r_res.last   <= 1'b1;
                                r_out_valid  <= 1'b1;
                            end else if (act == ACT_WRITE &&
                                         i_device_type == TYPE_FOREIGN) begin
                                r_res.status <= ST_FOREIGN;
                                r_res.last   <= 1'b1;
                                r_out_valid  <= 1'b1;
                            end else if (!r_enable) begin
                                r_res.direct <= 1'b1;
                                r_res.last   <= 1'b1;
                                r_out_valid  <= 1'b1;
                            end else begin
                                r_state <= S_SEARCH;
                            end
                        end else if (r_enable) begin
                            if (act == ACT_FLUSH_CLR) begin
                                r_hits   <= '0;
                                r_misses <= '0;
                            end
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit_now) begin
                        r_hits <= r_hits + 1'b1;
                        if (r_write) begin
                            r_dirty[r_prev] <= 1'b1;
                        end
                        r_res       <= '0;
                        r_res.hit   <= 1'b1;
                        r_res.slot  <= r_prev;
                        r_res.last  <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_q_ok && prev_last) begin
                        r_misses <= r_misses + 1'b1;
                        r_state  <= S_CLOCK_RD;
                    end else begin
                        r_prev <= r_idx;
                        r_idx  <= IDX_W'(r_idx + 1'b1);
                        r_q_ok <= 1'b1;
                    end
                end
                S_CLOCK_RD: begin
                    r_state <= S_CLOCK;
                end
                S_CLOCK: begin
                    r_hand <= IDX_W'(r_hand + 1'b1);
                    if (victim_now) begin
                        r_res       <= '0;
                        r_res.slot  <= r_hand;
                        r_res.fetch <= 1'b1;
                        r_res.last  <= 1'b1;
                        if (r_valid[r_hand] && r_dirty[r_hand]) begin
                            r_res.wb        <= 1'b1;
                            r_res.wb_sector <= tag_q.sector;
                            r_res.wb_type   <= tag_q.dtype;
                        end
                        r_valid[r_hand] <= 1'b1;
                        r_dirty[r_hand] <= r_write;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (r_q_ok) begin
                        r_res      <= '0;
                        r_res.slot <= r_prev;
                        r_res.last <= prev_last;
                        if (r_valid[r_prev] && r_dirty[r_prev]) begin
                            r_res.wb        <= 1'b1;
                            r_res.wb_sector <= tag_q.sector;
                            r_res.wb_type   <= tag_q.dtype;
                        end
                        r_valid[r_prev] <= 1'b0;
                        r_dirty[r_prev] <= 1'b0;
                        r_out_valid     <= 1'b1;
                        if (prev_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                    r_prev <= r_idx;
                    r_idx  <= IDX_W'(r_idx + 1'b1);
                    r_q_ok <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_result_valid     = r_out_valid;
    assign o_status           = r_res.status;
    assign o_hit              = r_res.hit;
    assign o_slot             = r_res.slot;
    assign o_fetch_needed     = r_res.fetch;
    assign o_writeback_needed = r_res.wb;
    assign o_writeback_sector = r_res.wb_sector;
    assign o_writeback_type   = r_res.wb_type;
    assign o_direct_access    = r_res.direct;
    assign o_last             = r_res.last;
    assign o_hit_count        = r_hits;
    assign o_miss_count       = r_misses;

endmodule

`default_nettype wire

[tb/tb_sector_cache_clock_policy_unit.sv]
`timescale 1ns / 1ps

module tb_sector_cache_clock_policy_unit;
    import sccp_pkg::*;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 128;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 90;

    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        t_idx              slot;
        logic              fetch;
        logic              wb;
        logic [SEC_W-1:0]  wb_sector;
        logic [TYPE_W-1:0] wb_type;
        logic              direct;
        logic              last;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } t_cache_reply;

    // Tag store and clock hand mirror plus the queue of replies still owed.
    class reply_board;
        logic [SEC_W-1:0]  tag_sector [ENTRIES];
        logic [TYPE_W-1:0] tag_type   [ENTRIES];
        bit                line_valid [ENTRIES];
        bit                line_dirty [ENTRIES];
        t_use              line_use   [ENTRIES];
        t_idx              hand;
        logic [CNT_W-1:0]  hits_total;
        logic [CNT_W-1:0]  misses_total;
        bit                enabled;
        t_cache_reply      replies_due [$];
        int                errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                tag_sector[i] = '0;
                tag_type[i]   = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_use[i]   = '0;
            end
            hand         = '0;
            hits_total   = '0;
            misses_total = '0;
            enabled      = 1'b0;
            errors       = 0;
        endfunction

        function void set_enable(bit en);
            enabled = en;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function void note_request(t_action act, logic [SEC_W-1:0] sector,
                                   logic [TYPE_W-1:0] dtype, logic [SEC_W-1:0] size);
            t_cache_reply r;
            t_cache_reply batch [$];
            int found;
            int i;
            t_idx victim;
            r = '0;
            r.last = 1'b1;
            if (act == ACT_READ || act == ACT_WRITE) begin
                if (sector >= size) begin
                    r.status = ST_RANGE;
                end else if (act == ACT_WRITE && dtype == TYPE_FOREIGN) begin
                    r.status = ST_FOREIGN;
                end else if (!enabled) begin
                    r.direct = 1'b1;
                end else begin
                    found = -1;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (found < 0 && line_valid[i] && tag_sector[i] == sector &&
                            tag_type[i] == dtype) begin
                            found = i;
                        end
                    end
                    if (found >= 0) begin
                        hits_total++;
                        if (line_use[found] != MAX_USE) begin
                            line_use[found]++;
                        end
                        if (act == ACT_WRITE) begin
                            line_dirty[found] = 1'b1;
                        end
                        r.hit  = 1'b1;
                        r.slot = t_idx'(found);
                    end else begin
                        misses_total++;
                        // second chance: age every used entry the hand passes
                        while (line_use[hand] != '0) begin
                            line_use[hand]--;
                            hand++;
                        end
                        victim = hand;
                        line_use[victim] = MAX_USE;
                        hand++;
                        r.slot  = victim;
                        r.fetch = 1'b1;
                        if (line_valid[victim] && line_dirty[victim]) begin
                            r.wb        = 1'b1;
                            r.wb_sector = tag_sector[victim];
                            r.wb_type   = tag_type[victim];
                        end
                        tag_sector[victim] = sector;
                        tag_type[victim]   = dtype;
                        line_valid[victim] = 1'b1;
                        line_dirty[victim] = (act == ACT_WRITE);
                    end
                end
                batch.push_back(r);
            end else if (enabled) begin
                for (i = 0; i < ENTRIES; i++) begin
                    r = '0;
                    r.slot = t_idx'(i);
                    r.last = (i == ENTRIES - 1);
                    if (line_valid[i] && line_dirty[i]) begin
                        r.wb        = 1'b1;
                        r.wb_sector = tag_sector[i];
                        r.wb_type   = tag_type[i];
                    end
                    batch.push_back(r);
                    line_valid[i] = 1'b0;
                    line_dirty[i] = 1'b0;
                    tag_sector[i] = '0;
                    tag_type[i]   = '0;
                end
                if (act == ACT_FLUSH_CLR) begin
                    for (i = 0; i < ENTRIES; i++) begin
                        line_use[i] = '0;
                    end
                    hits_total   = '0;
                    misses_total = '0;
                end
            end
            // counters are reported as they stand after the whole request
            foreach (batch[k]) begin
                batch[k].hits   = hits_total;
                batch[k].misses = misses_total;
                replies_due.push_back(batch[k]);
            end
        endfunction

        function void check_reply(t_cache_reply got);
            t_cache_reply want;
            string diffs;
            if (replies_due.size() == 0) begin
                note_error($sformatf("word with nothing pending: slot %0d last %0b",
                                     got.slot, got.last));
                return;
            end
            want = replies_due.pop_front();
            diffs = "";
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" status %0d/%0d", want.status, got.status)};
            if (got.hit !== want.hit)
                diffs = {diffs, $sformatf(" hit %0b/%0b", want.hit, got.hit)};
            if (got.slot !== want.slot)
                diffs = {diffs, $sformatf(" slot %0d/%0d", want.slot, got.slot)};
            if (got.fetch !== want.fetch)
                diffs = {diffs, $sformatf(" fetch %0b/%0b", want.fetch, got.fetch)};
            if (got.wb !== want.wb)
                diffs = {diffs, $sformatf(" writeback %0b/%0b", want.wb, got.wb)};
            if (got.wb_sector !== want.wb_sector)
                diffs = {diffs, $sformatf(" wb_sector %0h/%0h", want.wb_sector,
                                          got.wb_sector)};
            if (got.wb_type !== want.wb_type)
                diffs = {diffs, $sformatf(" wb_type %0d/%0d", want.wb_type, got.wb_type)};
            if (got.direct !== want.direct)
                diffs = {diffs, $sformatf(" direct %0b/%0b", want.direct, got.direct)};
            if (got.last !== want.last)
                diffs = {diffs, $sformatf(" last %0b/%0b", want.last, got.last)};
            if (got.hits !== want.hits)
                diffs = {diffs, $sformatf(" hits %0d/%0d", want.hits, got.hits)};
            if (got.misses !== want.misses)
                diffs = {diffs, $sformatf(" misses %0d/%0d", want.misses, got.misses)};
            if (diffs != "") begin
                note_error({"expected/actual:", diffs});
            end
        endfunction

        function void check_drained();
            if (replies_due.size() != 0) begin
                note_error($sformatf("%0d words never arrived", replies_due.size()));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [1:0]          i_action;
    logic [SEC_W-1:0]    i_sector;
    logic [TYPE_W-1:0]   i_device_type;
    logic [SEC_W-1:0]    i_device_sectors;
    logic                o_result_valid;
    logic [1:0]          o_status;
    logic                o_hit;
    logic [IDX_W-1:0]    o_slot;
    logic                o_fetch_needed;
    logic                o_writeback_needed;
    logic [SEC_W-1:0]    o_writeback_sector;
    logic [TYPE_W-1:0]   o_writeback_type;
    logic                o_direct_access;
    logic                o_last;
    logic [CNT_W-1:0]    o_hit_count;
    logic [CNT_W-1:0]    o_miss_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_data;

    reply_board          board;
    int                  quiet_cycles = 0;
    logic [SEC_W-1:0]    hot_sector [POOL_SIZE];
    logic [TYPE_W-1:0]   hot_type   [POOL_SIZE];

    sector_cache_clock_policy_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_action           (i_action),
        .i_sector           (i_sector),
        .i_device_type      (i_device_type),
        .i_device_sectors   (i_device_sectors),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_fetch_needed     (o_fetch_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_sector (o_writeback_sector),
        .o_writeback_type   (o_writeback_type),
        .o_direct_access    (o_direct_access),
        .o_last             (o_last),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Every word is taken on its single valid cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            board.check_reply('{o_status, o_hit, o_slot, o_fetch_needed, o_writeback_needed,
                                o_writeback_sector, o_writeback_type, o_direct_access,
                                o_last, o_hit_count, o_miss_count});
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap(bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 40) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(t_action act, logic [SEC_W-1:0] sector,
                                logic [TYPE_W-1:0] dtype, logic [SEC_W-1:0] size, int gap);
        i_start          <= 1'b1;
        i_action         <= act;
        i_sector         <= sector;
        i_device_type    <= dtype;
        i_device_sectors <= size;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        board.note_request(act, sector, dtype, size);
        // hold start high when the next request follows back to back
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        // a disabled flush gives no word, so allow time before moving on
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic set_cache_enable(bit en);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        board.set_enable(en);
    endtask

    initial begin
        int phase;
        int k;
        int pick;
        int roll;
        t_action act;
        logic [SEC_W-1:0] sector;
        logic [SEC_W-1:0] size;
        logic [TYPE_W-1:0] dtype;

        board            = new();
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_action         = '0;
        i_sector         = '0;
        i_device_type    = '0;
        i_device_sectors = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = 1'b0;

        for (k = 0; k < POOL_SIZE; k++) begin
            hot_sector[k] = $urandom;
            hot_type[k]   = TYPE_W'($urandom_range(0, 7));
        end
        hot_sector[0] = '0;
        hot_sector[1] = 32'hFFFF_FFFE;
        hot_sector[2] = 32'hFFFF_FFFF;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cache disabled out of reset
        send_request(ACT_READ,  32'd0, 3'd0, 32'd0, pick_gap(0));
        send_request(ACT_WRITE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, pick_gap(0));
        send_request(ACT_WRITE, 32'd10, TYPE_FOREIGN, 32'd100, pick_gap(0));
        send_request(ACT_READ,  32'hFFFF_FFFE, 3'd7, 32'hFFFF_FFFF, pick_gap(0));
        send_request(ACT_FLUSH, 32'd0, 3'd0, 32'd0, pick_gap(0));
        send_request(ACT_FLUSH_CLR, 32'd0, 3'd0, 32'd0, pick_gap(0));

        set_cache_enable(1'b1);
        send_request(ACT_READ,  32'd0, 3'd0, 32'd1, pick_gap(0));
        send_request(ACT_READ,  32'd0, 3'd0, 32'd1, pick_gap(0));
        send_request(ACT_WRITE, 32'd0, 3'd0, 32'd1, pick_gap(0));
        send_request(ACT_READ,  32'd0, 3'd1, 32'd1, pick_gap(0));
        send_request(ACT_WRITE, 32'hFFFF_FFFE, 3'd7, 32'hFFFF_FFFF, pick_gap(0));
        // range check wins over the foreign write check
        send_request(ACT_WRITE, 32'd5, TYPE_FOREIGN, 32'd5, pick_gap(0));
        send_request(ACT_READ,  32'd7, TYPE_FOREIGN, 32'd8, pick_gap(0));
        send_request(ACT_WRITE, 32'd7, 3'd6, 32'd8, pick_gap(0));
        repeat (3) send_request(ACT_READ, 32'd0, 3'd0, 32'd1, pick_gap(0));
        send_request(ACT_FLUSH, 32'd0, 3'd0, 32'd0, pick_gap(0));
        send_request(ACT_WRITE, 32'd3, 3'd2, 32'd4, pick_gap(0));
        send_request(ACT_READ,  32'd3, 3'd2, 32'd4, pick_gap(0));
        send_request(ACT_FLUSH_CLR, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, pick_gap(0));
        send_request(ACT_READ,  32'hAAAA_AAAA, 3'd3, 32'h5555_5555, pick_gap(0));
        send_request(ACT_READ,  32'h5555_5555, 3'd4, 32'hAAAA_AAAA, pick_gap(0));

        for (phase = 0; phase < PHASES; phase++) begin
            set_cache_enable(phase != 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                // no flushes in the first phase so the cache fills and evicts
                if (phase != 0 && roll < 2) begin
                    act = ACT_FLUSH;
                end else if (phase != 0 && roll < 3) begin
                    act = ACT_FLUSH_CLR;
                end else if (roll < 55) begin
                    act = ACT_READ;
                end else begin
                    act = ACT_WRITE;
                end
                if ($urandom_range(0, 9) < 8) begin
                    pick   = $urandom_range(0, POOL_SIZE - 1);
                    sector = hot_sector[pick];
                    dtype  = hot_type[pick];
                end else begin
                    sector = $urandom;
                    dtype  = TYPE_W'($urandom_range(0, 7));
                end
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    size = sector;
                end else if (roll == 1) begin
                    size = $urandom;
                end else begin
                    size = sector + 32'd1 + $urandom_range(0, 1000);
                    if (size <= sector) begin
                        size = 32'hFFFF_FFFF;
                    end
                end
                send_request(act, sector, dtype, size, pick_gap((k % 30) < 8));
            end
        end

        wait_idle();
        board.check_drained();
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/sccp_pkg.sv
design/sccp_tag_ram.sv
design/sccp_use_ram.sv
design/sector_cache_clock_policy_unit.sv
tb/tb_sector_cache_clock_policy_unit.sv
